/* hw/rtl/char_lcd_nibble_sequencer_assert.svh */
// Assertion macros used by the checker file of the LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// Checks a property on the rising clock edge, idle while reset is asserted.
`define CLCD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clcd assertion failed");

// Same check with a caller-supplied message string.
`define CLCD_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

/* hw/rtl/clcd_pkg.sv */
// Package with the codes, control word type and microcode table of the LCD sequencer.
package clcd_pkg;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_COMMAND = 3'd1,
    ACT_DATA    = 3'd2,
    ACT_CURSOR  = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_COMMAND_GAP   = 2'd0,
    CFG_CLEAR_SETTLE  = 2'd1,
    CFG_POWER_UP_WAIT = 2'd2,
    CFG_ENABLE_PULSE  = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    WAIT_ZERO,
    WAIT_POWER_UP,
    WAIT_WAKE_LONG,
    WAIT_WAKE_SHORT,
    WAIT_SHORT_GAP,
    WAIT_GAP,
    WAIT_SETTLE_GAP
  } wait_sel_e;

  typedef enum logic [1:0] {
    NIB_CONST,
    NIB_HIGH,
    NIB_LOW
  } nib_sel_e;

  typedef struct packed {
    nib_sel_e   nib_sel;
    logic [3:0] nib_const;
    wait_sel_e  wait_sel;
    logic       settle_en;
    logic       last;
  } ucode_t;

  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] InitEntry = 4'd0;
  localparam logic [StepW-1:0] ByteEntry = 4'd14;

  localparam logic [15:0] WakeLongUs  = 16'd5000;
  localparam logic [15:0] WakeShortUs = 16'd150;
  localparam logic [7:0]  CmdClear    = 8'h01;
  localparam logic [7:0]  CmdSetDdram = 8'h80;
  localparam logic [7:0]  Row1Offset  = 8'h40;

  localparam logic [15:0] ResetCommandGap = 16'd50;
  localparam logic [15:0] ResetClearSettle = 16'd2000;
  localparam logic [15:0] ResetPowerUpWait = 16'd20000;

  function automatic ucode_t uc(nib_sel_e s, logic [3:0] c, wait_sel_e w,
                                logic st, logic l);
    ucode_t r;
    r.nib_sel   = s;
    r.nib_const = c;
    r.wait_sel  = w;
    r.settle_en = st;
    r.last      = l;
    return r;
  endfunction

  // Init program occupies steps 0 to 13, the shared byte program steps 14 and 15.
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t r;
    unique case (step)
      4'd0:  r = uc(NIB_CONST, 4'h3, WAIT_POWER_UP,   1'b0, 1'b0);
      4'd1:  r = uc(NIB_CONST, 4'h3, WAIT_WAKE_LONG,  1'b0, 1'b0);
      4'd2:  r = uc(NIB_CONST, 4'h3, WAIT_WAKE_SHORT, 1'b0, 1'b0);
      4'd3:  r = uc(NIB_CONST, 4'h2, WAIT_WAKE_SHORT, 1'b0, 1'b0);
      4'd4:  r = uc(NIB_CONST, 4'h2, WAIT_SHORT_GAP,  1'b0, 1'b0);
      4'd5:  r = uc(NIB_CONST, 4'h8, WAIT_ZERO,       1'b0, 1'b0);
      4'd6:  r = uc(NIB_CONST, 4'h0, WAIT_GAP,        1'b0, 1'b0);
      4'd7:  r = uc(NIB_CONST, 4'h8, WAIT_ZERO,       1'b0, 1'b0);
      4'd8:  r = uc(NIB_CONST, 4'h0, WAIT_GAP,        1'b0, 1'b0);
      4'd9:  r = uc(NIB_CONST, 4'h1, WAIT_ZERO,       1'b0, 1'b0);
      4'd10: r = uc(NIB_CONST, 4'h0, WAIT_SETTLE_GAP, 1'b0, 1'b0);
      4'd11: r = uc(NIB_CONST, 4'h6, WAIT_ZERO,       1'b0, 1'b0);
      4'd12: r = uc(NIB_CONST, 4'h0, WAIT_GAP,        1'b0, 1'b0);
      4'd13: r = uc(NIB_CONST, 4'hC, WAIT_ZERO,       1'b0, 1'b1);
      4'd14: r = uc(NIB_HIGH,  4'h0, WAIT_GAP,        1'b0, 1'b0);
      4'd15: r = uc(NIB_LOW,   4'h0, WAIT_ZERO,       1'b1, 1'b1);
      default: r = uc(NIB_CONST, 4'h0, WAIT_ZERO,     1'b0, 1'b1);
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/char_lcd_nibble_sequencer.sv */
// Top level of the 4-bit character LCD request sequencer.
// Each accepted request is turned into enable-strobe items, one per cycle while the
// output side takes them: init gives 14 items, command, data, set cursor and clear
// give two, and actions 5 to 7 are taken and give none. A request is accepted when
// the sequencer is free and keeps it busy until the step counter, walking the
// microcode table, reaches the step marked last. A new request may be taken while
// the last strobe of the previous one still waits in the output register. Waits
// that include the command gap saturate at 65535.
module char_lcd_nibble_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic [5:0]  column_i,
  input  logic        row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        register_select_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] wait_before_us_o,
  output logic [15:0] settle_after_us_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] gap_q, settle_q, power_up_q;
  logic        busy_q, busy_d;
  logic [clcd_pkg::StepW-1:0] step_q, step_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q;
  logic        rs_q, clear_q;
  logic        in_fire, advance, start;
  logic [clcd_pkg::StepW-1:0] entry;
  logic [7:0]  req_byte;
  logic        req_rs, req_clear;
  clcd_pkg::ucode_t ucw;
  logic [15:0] addend, sum_sat, wait_val, settle_val;
  logic [16:0] sum;
  logic [3:0]  nib_val;
  logic        rs_oq, last_oq;
  logic [3:0]  nib_oq;
  logic [15:0] wait_oq, settle_oq;

  assign in_ready_o  = !busy_q;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign advance     = busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    start     = 1'b1;
    entry     = clcd_pkg::ByteEntry;
    req_byte  = byte_value_i;
    req_rs    = 1'b0;
    req_clear = 1'b0;
    unique case (clcd_pkg::action_e'(action_i))
      clcd_pkg::ACT_INIT: begin
        entry = clcd_pkg::InitEntry;
      end
      clcd_pkg::ACT_COMMAND: begin
      end
      clcd_pkg::ACT_DATA: begin
        req_rs = 1'b1;
      end
      clcd_pkg::ACT_CURSOR: begin
        req_byte = clcd_pkg::CmdSetDdram
                 | ((row_i ? clcd_pkg::Row1Offset : 8'h00) + {2'b00, column_i});
      end
      clcd_pkg::ACT_CLEAR: begin
        req_byte  = clcd_pkg::CmdClear;
        req_clear = 1'b1;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  assign ucw = clcd_pkg::ucode_rom(step_q);

  always_comb begin
    case (ucw.wait_sel)
      clcd_pkg::WAIT_SHORT_GAP:  addend = clcd_pkg::WakeShortUs;
      clcd_pkg::WAIT_SETTLE_GAP: addend = settle_q;
      default:                   addend = 16'd0;
    endcase
    sum     = {1'b0, addend} + {1'b0, gap_q};
    sum_sat = sum[16] ? 16'hFFFF : sum[15:0];
    unique case (ucw.wait_sel)
      clcd_pkg::WAIT_POWER_UP:   wait_val = power_up_q;
      clcd_pkg::WAIT_WAKE_LONG:  wait_val = clcd_pkg::WakeLongUs;
      clcd_pkg::WAIT_WAKE_SHORT: wait_val = clcd_pkg::WakeShortUs;
      clcd_pkg::WAIT_SHORT_GAP,
      clcd_pkg::WAIT_GAP,
      clcd_pkg::WAIT_SETTLE_GAP: wait_val = sum_sat;
      default:                   wait_val = 16'd0;
    endcase
    unique case (ucw.nib_sel)
      clcd_pkg::NIB_HIGH: nib_val = byte_q[7:4];
      clcd_pkg::NIB_LOW:  nib_val = byte_q[3:0];
      default:            nib_val = ucw.nib_const;
    endcase
    settle_val = (ucw.settle_en && clear_q) ? settle_q : 16'd0;
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = step_q + 1'b1;
      if (ucw.last) begin
        busy_d = 1'b0;
      end
    end else if (in_fire && start) begin
      busy_d = 1'b1;
      step_d = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      gap_q       <= clcd_pkg::ResetCommandGap;
      settle_q    <= clcd_pkg::ResetClearSettle;
      power_up_q  <= clcd_pkg::ResetPowerUpWait;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (clcd_pkg::cfg_index_e'(cfg_index_i))
          clcd_pkg::CFG_COMMAND_GAP:   gap_q      <= cfg_data_i;
          clcd_pkg::CFG_CLEAR_SETTLE:  settle_q   <= cfg_data_i;
          clcd_pkg::CFG_POWER_UP_WAIT: power_up_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && start) begin
      byte_q  <= req_byte;
      rs_q    <= req_rs;
      clear_q <= req_clear;
    end
    if (advance) begin
      rs_oq     <= rs_q;
      nib_oq    <= nib_val;
      wait_oq   <= wait_val;
      settle_oq <= settle_val;
      last_oq   <= ucw.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign register_select_o = rs_oq;
  assign nibble_o          = nib_oq;
  assign wait_before_us_o  = wait_oq;
  assign settle_after_us_o = settle_oq;
  assign last_o            = last_oq;

endmodule

/* hw/rtl/clcd_checker.sv */
// Port-level checker for the LCD sequencer and its bind to the top level.
`include "char_lcd_nibble_sequencer_assert.svh"

module clcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  action_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  nibble_o,
  input logic [15:0] wait_before_us_o,
  input logic [15:0] settle_after_us_o,
  input logic        last_o
);

  `CLCD_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(nibble_o) && $stable(last_o))
  `CLCD_ASSERT_MSG(a_settle_on_last, clk_i, rst_ni,
    out_valid_o && (settle_after_us_o != 16'd0) |-> last_o, "settle time before last item")
  `CLCD_ASSERT_MSG(a_last_no_wait, clk_i, rst_ni,
    out_valid_o && last_o |-> wait_before_us_o == 16'd0, "last strobe has a wait")
  `CLCD_ASSERT(a_busy_after_request, clk_i, rst_ni,
    in_valid_i && in_ready_o && (action_i <= clcd_pkg::ACT_CLEAR) |=> !in_ready_o)

endmodule

bind char_lcd_nibble_sequencer clcd_checker u_clcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .action_i         (action_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .nibble_o         (nibble_o),
  .wait_before_us_o (wait_before_us_o),
  .settle_after_us_o(settle_after_us_o),
  .last_o           (last_o)
);
